// ===== rtl/core/psmf_pkg.sv =====
package psmf_pkg;

  // Field widths of the item and result channels
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned FIRST_W = 6;

  // Position saturates here
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Default number of stored values
  localparam int unsigned STORE_DEPTH_DEF = 64;

endpackage

// ===== rtl/core/psmf_cell.sv =====
module psmf_cell
  import psmf_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] shift_in,
  output logic [DATA_W-1:0] shift_out,
  input  logic              cmp_en,
  input  logic [DATA_W-1:0] cmp_value,
  input  logic [DATA_W-1:0] target,
  input  logic [CNT_W-1:0]  count,
  output logic              match
);

  logic [DATA_W-1:0] stored_r;
  logic              match_r;
  logic [DATA_W:0]   sum;
  logic              match_nxt;

  // Widened sum cannot wrap
  always_comb begin
    sum       = {cmp_value[DATA_W-1], cmp_value} + {stored_r[DATA_W-1], stored_r};
    match_nxt = (count > CNT_W'(IDX)) && (sum == {target[DATA_W-1], target});
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      stored_r <= shift_in;
    end
    if (cmp_en) begin
      match_r <= match_nxt;
    end
  end

  assign shift_out = stored_r;
  assign match     = match_r;

endmodule

// ===== rtl/core/psmf_tree.sv =====
module psmf_tree
  import psmf_pkg::*;
#(
  parameter int unsigned DEPTH = STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic [DEPTH-1:0]           match,
  output logic                       root_hit,
  output logic [$clog2(DEPTH)-1:0]   root_idx
);

  localparam int unsigned LEVELS = $clog2(DEPTH);
  localparam int unsigned LEAVES = 1 << LEVELS;

  logic [LEAVES-1:0] leaf_hit;
  logic              node_hit_r [1:LEAVES-1];
  logic [LEVELS-1:0] node_idx_r [1:LEAVES-1];

  // Pad unused leaves with no match
  assign leaf_hit = LEAVES'(match);

  // Heap-ordered nodes, one register level per tree level; the lower leaf wins
  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    logic              lh;
    logic              rh;
    logic [LEVELS-1:0] li;
    logic [LEVELS-1:0] ri;

    if (2 * i >= LEAVES) begin : g_leaf
      assign lh = leaf_hit[2*i-LEAVES];
      assign rh = leaf_hit[2*i+1-LEAVES];
      assign li = LEVELS'(2*i-LEAVES);
      assign ri = LEVELS'(2*i+1-LEAVES);
    end else begin : g_inner
      assign lh = node_hit_r[2*i];
      assign rh = node_hit_r[2*i+1];
      assign li = node_idx_r[2*i];
      assign ri = node_idx_r[2*i+1];
    end

    always_ff @(posedge clk) begin
      node_hit_r[i] <= lh | rh;
      node_idx_r[i] <= lh ? li : ri;
    end
  end

  assign root_hit = node_hit_r[1];
  assign root_idx = node_idx_r[1];

endmodule

// ===== rtl/core/pair_sum_match_finder_core.sv =====
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+------------------------------
// item in  | in_value, in_last_item                       | in_valid / in_stall
// result   | out_found, out_first_index,                  | out_valid / out_stall
//          | out_second_index, out_store_overflow         |
// config   | cfg_wr_data (target sum)                     | cfg_wr_en, no wait
//
// An item searched against the store is compared in every cell at once, then passes
// through each level of the registered priority tree, and is then decided and stored.
// Items after a pair, up to the end of the array, are dropped without a search.
// Reset is synchronous, active low; it clears control state and the target, not the cells.
// A result waits in the output register; the next item is taken meanwhile, and the decide
// step holds only while an earlier result is still stalled.
module pair_sum_match_finder_core
  import psmf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_value,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [FIRST_W-1:0] out_first_index,
  output logic [POS_W-1:0]   out_second_index,
  output logic               out_store_overflow,
  input  logic               cfg_wr_en,
  input  logic [DATA_W-1:0]  cfg_wr_data
);

  localparam int unsigned CW     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned KW     = $clog2(STORE_DEPTH);
  localparam int unsigned LEVELS = KW;
  localparam int unsigned LW     = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_TREE   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   target_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                pair_done_r, pair_done_nxt;
  logic                ovf_r, ovf_nxt;
  logic [DATA_W-1:0]   cur_r;
  logic                last_r;
  logic [LW-1:0]       lvl_cnt_r, lvl_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [FIRST_W-1:0]  out_first_r, out_first_nxt;
  logic [POS_W-1:0]    out_second_r, out_second_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                in_accept;
  logic                shift_en;
  logic                decide_go;
  logic [DATA_W-1:0]   cell_value [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] cell_match;
  logic                root_hit;
  logic [KW-1:0]       root_idx;
  logic [CW-1:0]       newest_j;
  logic [CW+FIRST_W-1:0] newest_ext;
  logic                ovf_upd;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Row of cells: cell 0 holds the newest value, older ones move one cell on per store
  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] sh_in;
    if (k == 0) begin : g_head
      assign sh_in = cur_r;
    end else begin : g_body
      assign sh_in = cell_value[k-1];
    end
    psmf_cell #(
      .IDX   (k),
      .CNT_W (CW)
    ) u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .shift_in  (sh_in),
      .shift_out (cell_value[k]),
      .cmp_en    (in_accept),
      .cmp_value (in_value),
      .target    (target_r),
      .count     (count_r),
      .match     (cell_match[k])
    );
  end

  // Lowest matching cell is the newest earlier value
  psmf_tree #(
    .DEPTH (STORE_DEPTH)
  ) u_tree (
    .clk      (clk),
    .match    (cell_match),
    .root_hit (root_hit),
    .root_idx (root_idx)
  );

  // Cell k holds array index count-1-k; keep the low bits of it
  always_comb begin
    newest_j   = count_r - CW'(1) - CW'(root_idx);
    newest_ext = {{FIRST_W{1'b0}}, newest_j};
  end

  // Decide only once an earlier result has left or is leaving
  assign decide_go = !(out_valid_r && out_stall);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    pair_done_nxt  = pair_done_r;
    ovf_nxt        = ovf_r;
    lvl_cnt_nxt    = lvl_cnt_r;
    shift_en       = 1'b0;
    ovf_upd        = ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (pair_done_r) begin
            // drop the item: advance position, clear on the last one
            if (pos_r != POS_MAX) begin
              pos_nxt = pos_r + POS_W'(1);
            end
            if (in_last_item) begin
              count_nxt     = '0;
              pos_nxt       = '0;
              pair_done_nxt = 1'b0;
              ovf_nxt       = 1'b0;
            end
          end else begin
            lvl_cnt_nxt = LW'(LEVELS - 1);
            state_nxt   = ST_TREE;
          end
        end
      end

      ST_TREE: begin
        if (lvl_cnt_r == '0) begin
          state_nxt = ST_DECIDE;
        end else begin
          lvl_cnt_nxt = lvl_cnt_r - LW'(1);
        end
      end

      ST_DECIDE: begin
        if (decide_go) begin
          if (root_hit) begin
            out_valid_nxt  = 1'b1;
            out_found_nxt  = 1'b1;
            out_first_nxt  = newest_ext[FIRST_W-1:0];
            out_second_nxt = pos_r;
            out_ovf_nxt    = ovf_r;
            pair_done_nxt  = 1'b1;
          end else begin
            // store the value while there is room, otherwise flag overflow
            if (count_r < CW'(STORE_DEPTH)) begin
              shift_en  = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              ovf_upd = 1'b1;
            end
            ovf_nxt = ovf_upd;
            if (last_r) begin
              out_valid_nxt  = 1'b1;
              out_found_nxt  = 1'b0;
              out_first_nxt  = '0;
              out_second_nxt = '0;
              out_ovf_nxt    = ovf_upd;
            end
          end
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          if (last_r) begin
            count_nxt     = '0;
            pos_nxt       = '0;
            pair_done_nxt = 1'b0;
            ovf_nxt       = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      pair_done_r <= 1'b0;
      ovf_r       <= 1'b0;
      lvl_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      pair_done_r <= pair_done_nxt;
      ovf_r       <= ovf_nxt;
      lvl_cnt_r   <= lvl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
    end
  end

  // Payload: hold the item under search and the result fields
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r  <= in_value;
      last_r <= in_last_item;
    end
    out_found_r  <= out_found_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_first_index    = out_first_r;
  assign out_second_index   = out_second_r;
  assign out_store_overflow = out_ovf_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import psmf_pkg::*;
;

  localparam int unsigned DEPTH = STORE_DEPTH_DEF;

  // Slowest correct run: about 7k items with their search and sender gaps, some 300
  // results each waiting out a receiver stall, and one long hold-off. Take it many times over.
  localparam int unsigned CYCLE_LIMIT  = 600_000;
  // Leave a margin past the search for items that give no result.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned PHASE_ITEMS   = 170;

  localparam logic signed [DATA_W-1:0] SUM_MIN     = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] SUM_MAX     = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] LONG_TARGET = -32'sd5;

  typedef enum logic [1:0] {
    IDLE_SENDER_LIGHT,
    IDLE_RECEIVER_LIGHT,
    IDLE_NONE
  } idle_mode_t;

  typedef struct packed {
    logic               found;
    logic [FIRST_W-1:0] first_index;
    logic [POS_W-1:0]   second_index;
    logic               store_overflow;
  } pair_result_t;

  // Pair search predictor and the queue of results it expects, oldest first.
  class pair_scoreboard;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] cells [DEPTH];
    int unsigned              filled;
    logic [POS_W-1:0]         pos;
    bit                       matched;
    bit                       spilled;
    pair_result_t             awaited_q [$];
    int unsigned errors, items, searched, arrays, hits, misses, spills, saturated;

    function new();
      target = '0;
      clear_array();
    endfunction

    function void clear_array();
      filled  = 0;
      pos     = '0;
      matched = 1'b0;
      spilled = 1'b0;
    endfunction

    function void set_target(logic signed [DATA_W-1:0] t);
      target = t;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function void push_result(pair_result_t r);
      awaited_q = {awaited_q, r};
      if (r.store_overflow) spills++;
    endfunction

    // Work out what one accepted item gives, at full width so no sum wraps.
    function void note_item(logic [DATA_W-1:0] raw, logic last);
      pair_result_t             r;
      logic signed [DATA_W-1:0] v;
      bit                       hit;
      int unsigned              hit_at;
      v      = raw;
      hit    = 1'b0;
      hit_at = 0;
      items++;
      if (!matched) begin
        searched++;
        // newest matching cell wins
        for (int unsigned j = 0; j < filled; j++) begin
          if (longint'(v) + longint'(cells[j]) == longint'(target)) begin
            hit    = 1'b1;
            hit_at = j;
          end
        end
        if (hit) begin
          r.found          = 1'b1;
          r.first_index    = hit_at[FIRST_W-1:0];
          r.second_index   = pos;
          r.store_overflow = spilled;
          matched          = 1'b1;
          hits++;
          if (pos == POS_MAX) saturated++;
          push_result(r);
        end else begin
          if (filled < DEPTH) begin
            cells[filled] = v;
            filled++;
          end else begin
            spilled = 1'b1;
          end
          if (last) begin
            r                = '0;
            r.store_overflow = spilled;
            misses++;
            push_result(r);
          end
        end
      end
      if (pos != POS_MAX) pos++;
      if (last) begin
        arrays++;
        clear_array();
      end
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(pair_result_t got);
      pair_result_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("result with nothing awaited: found=%0b first=%0d second=%0d ovf=%0b",
                         got.found, got.first_index, got.second_index, got.store_overflow));
        return;
      end
      want = awaited_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.first_index !== want.first_index)
        report($sformatf("first_index %0d, want %0d", got.first_index, want.first_index));
      if (got.second_index !== want.second_index)
        report($sformatf("second_index %0d, want %0d", got.second_index, want.second_index));
      if (got.store_overflow !== want.store_overflow)
        report($sformatf("store_overflow %0b, want %0b", got.store_overflow,
                         want.store_overflow));
    endtask
  endclass

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [DATA_W-1:0]  in_value     = '0;
  logic               in_last_item = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               out_found;
  logic [FIRST_W-1:0] out_first_index;
  logic [POS_W-1:0]   out_second_index;
  logic               out_store_overflow;
  logic               cfg_wr_en    = 1'b0;
  logic [DATA_W-1:0]  cfg_wr_data  = '0;

  pair_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    hold_left     = 0;
  int unsigned    cycles        = 0;
  int unsigned    targets_used  = 1;

  pair_sum_match_finder_core #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_first_index   (out_first_index),
    .out_second_index  (out_second_index),
    .out_store_overflow(out_store_overflow),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: a long hold-off when one is pending, else random stalls at the current rate.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every accepted result against the oldest one awaited.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(pair_result_t'({out_found, out_first_index, out_second_index,
                                      out_store_overflow}));
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_idle_mode(idle_mode_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 11;
        recv_idle_pct = 52;
      end
      IDLE_RECEIVER_LIGHT: begin
        send_idle_pct = 52;
        recv_idle_pct = 11;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one item, idling at random first; hold the payload until it is taken.
  task automatic send_item(logic [DATA_W-1:0] v, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_last_item <= last;
    do @(posedge clk); while (in_stall);
    sb.note_item(v, last);
  endtask

  // Drop valid, wait for every awaited result, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic signed [DATA_W-1:0] t);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_target(t);
    targets_used++;
  endtask

  // One array of random length; mix complements of earlier values, repeats and extremes
  // so that pairs turn up at varied depths.
  task automatic send_random_array();
    logic signed [DATA_W-1:0] sent [$];
    logic signed [DATA_W-1:0] v;
    longint                   want;
    int unsigned              len;
    int unsigned              roll;
    roll = $urandom_range(99);
    if (roll < 70)      len = $urandom_range(16, 1);
    else if (roll < 92) len = $urandom_range(63, 17);
    else                len = $urandom_range(90, 64);
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      v    = $urandom;
      if (roll < 8 && sent.size() != 0) begin
        want = longint'(sb.target) - longint'(sent[$urandom_range(sent.size() - 1)]);
        if (want >= longint'(SUM_MIN) && want <= longint'(SUM_MAX)) v = want[DATA_W-1:0];
      end else if (roll < 14 && sent.size() != 0) begin
        v = sent[$urandom_range(sent.size() - 1)];
      end else if (roll < 28) begin
        case ($urandom_range(4))
          0:       v = SUM_MIN;
          1:       v = SUM_MAX;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end else if (roll < 60) begin
        v = $urandom_range(100) - 50;
      end
      sent = {sent, v};
      send_item(v, i == len - 1);
    end
  endtask

  initial begin : stimulus
    logic signed [DATA_W-1:0] kept [$];
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] t;
    int unsigned              goal;
    sb = new();
    set_idle_mode(IDLE_SENDER_LIGHT);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Target zero from reset: pair on the last item, no wrap of two minimum values,
    // repeated partner (newest wins, rest ignored), no pair, lone item.
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b1);
    send_item(SUM_MIN, 1'b0);
    send_item(SUM_MIN, 1'b0);
    send_item(32'sd7, 1'b1);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd9, 1'b0);
    send_item(32'sd1, 1'b1);
    send_item(SUM_MAX, 1'b0);
    send_item(32'sd42, 1'b1);
    send_item(32'sd0, 1'b1);
    settle();
    write_target(SUM_MAX);
    send_item(SUM_MAX, 1'b0);
    send_item(32'sd0, 1'b1);
    settle();
    write_target(SUM_MIN);
    send_item(SUM_MIN, 1'b0);
    send_item(32'sd0, 1'b1);
    send_item(-32'sd1, 1'b0);
    send_item(SUM_MIN + 1, 1'b1);
    settle();
    // two maximum values would wrap to -2; the wide sum must not match
    write_target(-32'sd2);
    send_item(SUM_MAX, 1'b0);
    send_item(SUM_MAX, 1'b1);
    settle();

    // Store full: pair only among stored cells, overflow flagged; then a position that
    // saturates before the pair is found.
    set_idle_mode(IDLE_RECEIVER_LIGHT);
    write_target(LONG_TARGET);
    for (int i = 0; i < 70; i++) begin
      if (i == 69) v = LONG_TARGET - kept[10];
      else         v = $urandom_range(1000, 1);
      kept = {kept, v};
      send_item(v, 1'b0);
    end
    send_item(32'sd77, 1'b1);
    for (int i = 0; i < 66; i++) send_item($urandom_range(1000, 1), i == 65);
    kept.delete();
    for (int i = 0; i < 4100; i++) begin
      v = $urandom_range(1000, 1);
      if (i < 64) kept = {kept, v};
      send_item(v, 1'b0);
    end
    send_item(LONG_TARGET - kept[3], 1'b1);
    settle();

    // Random arrays under each idling pattern in turn.
    goal = sb.searched;
    for (int p = 0; p < 6; p++) begin
      set_idle_mode(p < 2 ? IDLE_SENDER_LIGHT : (p < 4 ? IDLE_RECEIVER_LIGHT : IDLE_NONE));
      case (p)
        0:       t = '0;
        1:       t = SUM_MIN;
        2:       t = SUM_MAX;
        3:       t = $urandom_range(200) - 100;
        default: t = $urandom;
      endcase
      // hold the receiver off while lone items keep coming, so the block backs up
      if (p == 1) hold_left = HOLD_CYCLES;
      write_target(t);
      if (p == 1)
        for (int i = 0; i < 40; i++) send_item($urandom, 1'b1);
      goal += PHASE_ITEMS;
      while (sb.searched < goal) send_random_array();
      settle();
    end

    $display("covered %0d items (%0d searched) in %0d arrays under %0d target settings",
             sb.items, sb.searched, sb.arrays, targets_used);
    $display("results: %0d pairs, %0d not found, %0d after store overflow, %0d at top position",
             sb.hits, sb.misses, sb.spills, sb.saturated);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
